>>> rtl/lineup_step_controller_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the line-up step controller
// Immediate-consequence and next-cycle property forms.
// ---------------------------------------------------------------------------
`ifndef LINEUP_STEP_CONTROLLER_UNIT_ASSERT_SVH
`define LINEUP_STEP_CONTROLLER_UNIT_ASSERT_SVH

// Check that cond holds whenever trig holds.
`define LSC_ASSERT_NOW(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("lsc assertion failed");

// Check that cond holds in the cycle after trig.
`define LSC_ASSERT_NEXT(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("lsc assertion failed");

`endif

>>> rtl/lsc_pkg.sv
// ---------------------------------------------------------------------------
// lsc_pkg
// Types, field widths and fixed constants of the line-up step controller.
// ---------------------------------------------------------------------------
package lsc_pkg;

  localparam int BALL_W      = 14;
  localparam int GAP_W       = 10;
  localparam int LIM_W       = 9;
  localparam int CNT_W       = 8;
  localparam int STEPLEN_W   = 8;
  localparam int TURN_IN_W   = 15;
  localparam int MOVE_W      = 10;
  localparam int TURN_OUT_W  = 12;
  localparam int SUM_W       = 15;
  localparam int GAIN_W      = 11;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 10;
  localparam int IN_DATA_W   = 56;
  localparam int OUT_DATA_W  = 32;

  localparam int BALL_X_LSB    = 0;
  localparam int BALL_Y_LSB    = 14;
  localparam int FOOT_BIT      = 28;
  localparam int KICK_BIT      = 29;
  localparam int STEPLEN_LSB   = 30;
  localparam int TURN_REQ_LSB  = 38;

  localparam int DRIBBLE_LEFT_GAP = 40;
  localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;

  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = 4;
  localparam int SCALE_BITS   = 16;
  localparam int XY_W         = 36;
  localparam int Z_W          = 28;
  localparam int Z_FRAC       = 24;

  localparam longint PI_Z      = 64'sd52707179;
  localparam longint HALF_PI_Z = 64'sd26353589;
  localparam longint DEG30_Z   = 64'sd8784530;
  localparam longint DEG20_Z   = 64'sd5856353;

  localparam logic signed [Z_W-1:0] ATAN_Z [CORDIC_STEPS] = '{
    28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
    28'sd1047214,  28'sd524117,  28'sd262123,  28'sd131069,
    28'sd65536,    28'sd32768,   28'sd16384,   28'sd8192,
    28'sd4096,     28'sd2048,    28'sd1024,    28'sd512
  };

  localparam logic [CFG_IDX_W-1:0] REG_BALL_STANDOFF = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIDE_GAP      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OVER_LIMIT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIDE_LIMIT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DONE_COUNT    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FORWARD   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SIDE      = 3'd7;

  typedef struct packed {
    logic signed [GAP_W-1:0] ball_standoff;
    logic signed [GAP_W-1:0] side_gap;
    logic signed [GAP_W-1:0] over_limit;
    logic signed [GAP_W-1:0] short_limit;
    logic        [LIM_W-1:0] side_limit;
    logic        [CNT_W-1:0] done_count;
    logic        [LIM_W-1:0] max_forward;
    logic        [LIM_W-1:0] max_side;
  } lsc_cfg_t;

endpackage

>>> rtl/lsc_cfg.sv
// ---------------------------------------------------------------------------
// lsc_cfg
// Configuration register file, written through a plain write port.
// ---------------------------------------------------------------------------
module lsc_cfg
  import lsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output lsc_cfg_t              cfg
);

  lsc_cfg_t regs;

  assign cfg = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.ball_standoff <= '0;
      regs.side_gap      <= '0;
      regs.over_limit    <= -10'sd35;
      regs.short_limit   <= 10'sd25;
      regs.side_limit    <= 9'd10;
      regs.done_count    <= 8'd1;
      regs.max_forward   <= 9'd60;
      regs.max_side      <= 9'd35;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BALL_STANDOFF: regs.ball_standoff <= $signed(cfg_data);
        REG_SIDE_GAP:      regs.side_gap      <= $signed(cfg_data);
        REG_OVER_LIMIT:    regs.over_limit    <= $signed(cfg_data);
        REG_SHORT_LIMIT:   regs.short_limit   <= $signed(cfg_data);
        REG_SIDE_LIMIT:    regs.side_limit    <= cfg_data[LIM_W-1:0];
        REG_DONE_COUNT:    regs.done_count    <= cfg_data[CNT_W-1:0];
        REG_MAX_FORWARD:   regs.max_forward   <= cfg_data[LIM_W-1:0];
        REG_MAX_SIDE:      regs.max_side      <= cfg_data[LIM_W-1:0];
      endcase
    end
  end

endmodule

>>> rtl/lsc_cordic.sv
// ---------------------------------------------------------------------------
// lsc_cordic
// Iterative vectoring CORDIC: ball heading, one shift-add step per cycle.
// ---------------------------------------------------------------------------
module lsc_cordic
  import lsc_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = 12,
  parameter int AW = 18
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [BALL_W-1:0] ball_x,
  input  logic signed [BALL_W-1:0] ball_y,
  output logic                     done,
  output logic signed [AW-1:0]     heading
);

  localparam int SHIFT = Z_FRAC - ANGLE_FRAC_BITS;
  localparam logic signed [Z_W-1:0] ROUND_Z = Z_W'(64'sd1 <<< (SHIFT - 1));
  localparam logic signed [Z_W-1:0] HALF_PI = Z_W'(HALF_PI_Z);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);

  logic                    busy;
  logic [STEP_W-1:0]       step;
  logic                    at_origin;
  logic signed [XY_W-1:0]  x, y;
  logic signed [Z_W-1:0]   z;
  logic signed [XY_W-1:0]  x_init, y_init, x_scaled, y_scaled;
  logic signed [Z_W-1:0]   z_init;
  logic signed [XY_W-1:0]  dx, dy, x_next, y_next;
  logic signed [Z_W-1:0]   z_next, z_round;

  assign x_scaled = {{(XY_W - BALL_W - SCALE_BITS){ball_x[BALL_W-1]}}, ball_x,
                     {SCALE_BITS{1'b0}}};
  assign y_scaled = {{(XY_W - BALL_W - SCALE_BITS){ball_y[BALL_W-1]}}, ball_y,
                     {SCALE_BITS{1'b0}}};

  always_comb begin
    x_init = x_scaled;
    y_init = y_scaled;
    z_init = '0;
    if (x_scaled[XY_W-1]) begin
      if (!y_scaled[XY_W-1]) begin
        x_init = y_scaled;
        y_init = -x_scaled;
        z_init = HALF_PI;
      end else begin
        x_init = -y_scaled;
        y_init = x_scaled;
        z_init = -HALF_PI;
      end
    end
  end

  assign dx = y >>> step;
  assign dy = x >>> step;

  always_comb begin
    if (!y[XY_W-1]) begin
      x_next = x + dx;
      y_next = y - dy;
      z_next = z + ATAN_Z[step];
    end else begin
      x_next = x - dx;
      y_next = y + dy;
      z_next = z - ATAN_Z[step];
    end
  end

  assign z_round = z_next + ROUND_Z;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == STEP_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x         <= x_init;
      y         <= y_init;
      z         <= z_init;
      at_origin <= (ball_x == '0) && (ball_y == '0);
    end else if (busy) begin
      x <= x_next;
      y <= y_next;
      z <= z_next;
      if (step == STEP_LAST) begin
        heading <= at_origin ? '0 : AW'(z_round >>> SHIFT);
      end
    end
  end

endmodule

>>> rtl/lsc_turn.sv
// ---------------------------------------------------------------------------
// lsc_turn
// Turn limiter: one shared adder sequenced through difference, wrap and limit, then scale and clamp.
// ---------------------------------------------------------------------------
module lsc_turn
  import lsc_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = 12,
  parameter int TURN_GAIN_Q8 = 256,
  parameter int AW = 18
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [TURN_IN_W-1:0]  turn_request,
  input  logic signed [AW-1:0]         heading,
  output logic                         done,
  output logic signed [TURN_OUT_W-1:0] turn_step
);

  localparam int SHIFT = Z_FRAC - ANGLE_FRAC_BITS;
  localparam longint HALF = longint'(1) <<< (SHIFT - 1);
  localparam longint PI_I  = (PI_Z + HALF) >>> SHIFT;
  localparam longint D30_I = (DEG30_Z + HALF) >>> SHIFT;
  localparam longint D20_I = (DEG20_Z + HALF) >>> SHIFT;
  localparam int MW = AW + GAIN_W;

  localparam logic signed [AW-1:0] PI_A      = AW'(PI_I);
  localparam logic signed [AW-1:0] NEG_PI_A  = AW'(-PI_I);
  localparam logic signed [AW-1:0] TWO_PI_A  = AW'(2 * PI_I);
  localparam logic signed [AW-1:0] NEG_2PI_A = AW'(-2 * PI_I);
  localparam logic signed [AW-1:0] D30_A     = AW'(D30_I);
  localparam logic signed [AW-1:0] NEG_D30_A = AW'(-D30_I);
  localparam logic [AW-1:0] D20_A = AW'(D20_I);
  localparam logic [MW-1:0] D20_M = MW'(D20_I);
  localparam logic [GAIN_W-1:0] GAIN = GAIN_W'(TURN_GAIN_Q8);

  localparam logic [2:0] T_IDLE  = 3'd0;
  localparam logic [2:0] T_DIFF  = 3'd1;
  localparam logic [2:0] T_WRAP1 = 3'd2;
  localparam logic [2:0] T_CMP   = 3'd3;
  localparam logic [2:0] T_WRAP2 = 3'd4;
  localparam logic [2:0] T_SCALE = 3'd5;
  localparam logic [2:0] T_CLAMP = 3'd6;

  logic [2:0]           state;
  logic signed [AW-1:0] turn_q, heading_q, acc;
  logic signed [AW-1:0] op_a, op_b, sum;
  logic                 out_range, over30, under30, neg;
  logic [AW-1:0]        mag, lim;
  logic [MW-1:0]        prod, scaled;
  logic signed [AW-1:0] result;

  assign out_range = (acc > PI_A) || (acc <= NEG_PI_A);
  assign over30    = acc > D30_A;
  assign under30   = acc < NEG_D30_A;

  always_comb begin
    unique case (state)
      T_DIFF: begin
        op_a = turn_q;
        op_b = -heading_q;
      end
      T_WRAP1, T_WRAP2: begin
        op_a = acc;
        op_b = (acc > PI_A) ? NEG_2PI_A : TWO_PI_A;
      end
      T_CMP: begin
        op_a = heading_q;
        op_b = over30 ? D30_A : NEG_D30_A;
      end
      default: begin
        op_a = acc;
        op_b = '0;
      end
    endcase
  end

  assign sum    = op_a + op_b;
  assign mag    = acc[AW-1] ? AW'(-acc) : AW'(acc);
  assign scaled = prod >> 8;
  assign lim    = (scaled > D20_M) ? D20_A : scaled[AW-1:0];
  assign result = neg ? -$signed(lim) : $signed(lim);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        T_IDLE:  if (start) state <= T_DIFF;
        T_DIFF:  state <= T_WRAP1;
        T_WRAP1: if (!out_range) state <= T_CMP;
        T_CMP:   state <= (over30 || under30) ? T_WRAP2 : T_SCALE;
        T_WRAP2: if (!out_range) state <= T_SCALE;
        T_SCALE: state <= T_CLAMP;
        T_CLAMP: begin
          state <= T_IDLE;
          done  <= 1'b1;
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      T_IDLE: begin
        if (start) begin
          turn_q    <= AW'(turn_request);
          heading_q <= heading;
        end
      end
      T_DIFF: acc <= sum;
      T_WRAP1, T_WRAP2: if (out_range) acc <= sum;
      T_CMP: acc <= (over30 || under30) ? sum : turn_q;
      T_SCALE: begin
        prod <= MW'(mag) * MW'(GAIN);
        neg  <= acc[AW-1];
      end
      T_CLAMP: turn_step <= result[TURN_OUT_W-1:0];
      default: ;
    endcase
  end

endmodule

>>> rtl/lineup_step_controller_unit.sv
// ---------------------------------------------------------------------------
// lineup_step_controller_unit
// Line-up step controller: gaps, qualifying counter, clamped steps and turn.
//
// s_* carries input transactions; s_tuser set clears the qualifying counter
// and returns no result, otherwise exactly one result transaction leaves on
// m_*. Write cfg_we/cfg_index/cfg_data only while the block is idle.
// A lined-up evaluation goes from the gap state straight to the output
// register; any other one goes through the gaps, 16 CORDIC steps, the shared
// turn adder (one more adder step when the turn is pulled to within 30 degrees
// of the heading, one per 2*pi wrap, at most two) and the hand-off to the
// output register. s_tready is high only while nothing is in work, so the
// block takes no new input before it is through with the last one; a
// counter clear is done in the accepting cycle and leaves the block ready.
// rst clears the counter, restores the configuration defaults and drops all
// valid state. A result waits in the output register while m_tready is low;
// the next input is accepted meanwhile and its result holds until that
// register is free.
// ---------------------------------------------------------------------------
module lineup_step_controller_unit
  import lsc_pkg::*;
#(
  parameter int TURN_GAIN_Q8 = 256,
  parameter int ANGLE_FRAC_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // ball_x[13:0], ball_y[27:14], foot_right[28], kick_mode[29],
  // step_length[37:30], turn_request[52:38], zero[55:53]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // command[0]
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // forward_step[9:0], side_step[19:10], turn_step[31:20]
  output logic [OUT_DATA_W-1:0] m_tdata,
  // lined_up[0]
  output logic                  m_tuser,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = ((ANGLE_FRAC_BITS > 12) ? ANGLE_FRAC_BITS : 12) + 6;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_GAP    = 3'd1;
  localparam logic [2:0] S_CORDIC = 3'd2;
  localparam logic [2:0] S_TURN   = 3'd3;
  localparam logic [2:0] S_OUT    = 3'd4;

  lsc_cfg_t cfg;

  logic [2:0]                  state;
  logic [CNT_W-1:0]            count;
  logic signed [BALL_W-1:0]    ball_x, ball_y;
  logic                        foot_right, kick_mode;
  logic [STEPLEN_W-1:0]        step_length;
  logic signed [TURN_IN_W-1:0] turn_request;

  logic                        res_lined;
  logic signed [MOVE_W-1:0]    res_fwd, res_side;
  logic signed [TURN_OUT_W-1:0] res_turn;

  logic signed [GAP_W-1:0]     lgap;
  logic signed [SUM_W-1:0]     gx, gy, gy_abs;
  logic                        qualified, lined;
  logic [CNT_W-1:0]            count_next;
  logic                        accept, out_free;
  logic                        cordic_start, cordic_done, turn_start, turn_done;
  logic signed [AW-1:0]        heading;
  logic signed [TURN_OUT_W-1:0] turn_step;

  function automatic logic signed [MOVE_W-1:0] clamp_step(
    input logic signed [SUM_W-1:0] g,
    input logic [LIM_W-1:0] lim
  );
    logic signed [SUM_W-1:0] a;
    logic signed [MOVE_W-1:0] m;
    a = g[SUM_W-1] ? -g : g;
    if (a > SUM_W'($signed({1'b0, lim}))) m = MOVE_W'($signed({1'b0, lim}));
    else m = a[MOVE_W-1:0];
    return g[SUM_W-1] ? -m : m;
  endfunction

  lsc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lsc_cordic #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .AW              (AW)
  ) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cordic_start),
    .ball_x  (ball_x),
    .ball_y  (ball_y),
    .done    (cordic_done),
    .heading (heading)
  );

  lsc_turn #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .TURN_GAIN_Q8    (TURN_GAIN_Q8),
    .AW              (AW)
  ) u_turn (
    .clk          (clk),
    .rst          (rst),
    .start        (turn_start),
    .turn_request (turn_request),
    .heading      (heading),
    .done         (turn_done),
    .turn_step    (turn_step)
  );

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign lgap = kick_mode ? cfg.side_gap : GAP_W'(DRIBBLE_LEFT_GAP);
  assign gy   = foot_right ? SUM_W'(ball_y) + SUM_W'(lgap)
                           : SUM_W'(ball_y) - SUM_W'(lgap);
  assign gx   = SUM_W'(ball_x) - SUM_W'(cfg.ball_standoff)
              - SUM_W'($signed({1'b0, step_length}));
  assign gy_abs = gy[SUM_W-1] ? -gy : gy;

  assign qualified = (gx < SUM_W'(cfg.short_limit)) && (gx > SUM_W'(cfg.over_limit))
                  && (gy_abs < SUM_W'($signed({1'b0, cfg.side_limit})));

  always_comb begin
    if (qualified) count_next = (count == CNT_MAX) ? count : count + CNT_W'(1);
    else count_next = (count == '0) ? count : count - CNT_W'(1);
  end

  assign lined        = count_next >= cfg.done_count;
  assign cordic_start = (state == S_GAP) && !lined;
  assign turn_start   = (state == S_CORDIC) && cordic_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (state == S_OUT && out_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (s_tuser) count <= '0;
            else state <= S_GAP;
          end
        end
        S_GAP: begin
          count <= lined ? '0 : count_next;
          state <= lined ? S_OUT : S_CORDIC;
        end
        S_CORDIC: if (cordic_done) state <= S_TURN;
        S_TURN:   if (turn_done) state <= S_OUT;
        S_OUT:    if (out_free) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ball_x       <= $signed(s_tdata[BALL_X_LSB +: BALL_W]);
      ball_y       <= $signed(s_tdata[BALL_Y_LSB +: BALL_W]);
      foot_right   <= s_tdata[FOOT_BIT];
      kick_mode    <= s_tdata[KICK_BIT];
      step_length  <= s_tdata[STEPLEN_LSB +: STEPLEN_W];
      turn_request <= $signed(s_tdata[TURN_REQ_LSB +: TURN_IN_W]);
    end
    if (state == S_GAP) begin
      res_lined <= lined;
      res_fwd   <= lined ? '0 : clamp_step(gx, cfg.max_forward);
      res_side  <= lined ? '0 : clamp_step(gy, cfg.max_side);
      res_turn  <= '0;
    end
    if (state == S_TURN && turn_done) res_turn <= turn_step;
    if (state == S_OUT && out_free) begin
      m_tdata <= {res_turn, res_side, res_fwd};
      m_tuser <= res_lined;
    end
  end

endmodule

>>> rtl/lsc_checker.sv
// ---------------------------------------------------------------------------
// lsc_checker
// Port-level checks of the line-up step controller, bound to the top level.
// ---------------------------------------------------------------------------
`include "lineup_step_controller_unit_assert.svh"

module lsc_checker
  import lsc_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  s_tuser,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic                  m_tuser
);

  `LSC_ASSERT_NOW(a_lined_zero, clk, rst, m_tvalid && m_tuser, m_tdata == '0)
  `LSC_ASSERT_NEXT(a_busy_after_eval, clk, rst, s_tvalid && s_tready && !s_tuser, !s_tready)
  `LSC_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `LSC_ASSERT_NOW(a_fwd_range, clk, rst, m_tvalid, m_tdata[MOVE_W-1:0] != 10'h200)

endmodule

bind lineup_step_controller_unit lsc_checker u_lsc_checker (.*);

>>> test/lineup_step_controller_unit_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lineup_step_controller_unit_test
// Self-checking bench for the line-up step controller. A queue-fed driver
// sends step requests and counter clears while a monitor checks every result
// against a bit-exact model of the gaps, the qualifying counter, the clamped
// steps and the CORDIC-based turn. Several register settings, extremes
// included, are run under varying source and sink stalls.
// ---------------------------------------------------------------------------
module lineup_step_controller_unit_test
  import lsc_pkg::*;
();

  localparam int TURN_GAIN  = 256;
  localparam int ANG_FRAC   = 12;
  localparam int CYCLE_CAP  = 1000000;
  localparam int DRAIN_WAIT = 64;
  localparam int BALL_MIN   = -8192;
  localparam int BALL_MAX   = 8191;
  localparam int TURN_MAX   = 12868;

  typedef struct packed {
    logic                        clear;
    logic signed [BALL_W-1:0]    ball_x;
    logic signed [BALL_W-1:0]    ball_y;
    logic                        foot_right;
    logic                        kick_mode;
    logic [STEPLEN_W-1:0]        step_len;
    logic signed [TURN_IN_W-1:0] turn_req;
  } lineup_req_t;

  typedef struct packed {
    logic                         lined_up;
    logic signed [MOVE_W-1:0]     fwd_step;
    logic signed [MOVE_W-1:0]     side_step;
    logic signed [TURN_OUT_W-1:0] turn_step;
  } step_cmd_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  lineup_req_t pending_reqs[$];
  step_cmd_t   expected_cmds[$];
  lineup_req_t held_req;
  step_cmd_t   pred_cmd;
  step_cmd_t   want_cmd;
  step_cmd_t   got_cmd;
  lsc_cfg_t    cfg;
  int          qual_cnt = 0;
  int          send_idle;
  int          recv_idle;
  int          mismatches = 0;
  int          n_checked = 0;
  int          n_lined = 0;
  int          n_clears = 0;
  int          cycles = 0;

  lineup_step_controller_unit #(
    .TURN_GAIN_Q8(TURN_GAIN),
    .ANGLE_FRAC_BITS(ANG_FRAC)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---- prediction ---------------------------------------------------------

  function automatic longint fix_angle(longint z);
    int s;
    s = Z_FRAC - ANG_FRAC;
    return (z + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint ball_heading(longint bx, longint by);
    longint x, y, z, t, dx, dy;
    if (bx == 0 && by == 0) return 0;
    x = bx * 65536;
    y = by * 65536;
    z = 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = HALF_PI_Z;
      end else begin
        t = x; x = -y; y = t; z = -HALF_PI_Z;
      end
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'(ATAN_Z[i]);
      end else begin
        x -= dx; y += dy; z -= longint'(ATAN_Z[i]);
      end
    end
    return fix_angle(z);
  endfunction

  function automatic longint wrap_pi(longint v, longint p);
    while (v > p) v -= 2 * p;
    while (v <= -p) v += 2 * p;
    return v;
  endfunction

  function automatic longint mag_clamp(longint v, longint lim);
    longint a;
    a = v < 0 ? -v : v;
    if (a > lim) a = lim;
    return v < 0 ? -a : a;
  endfunction

  function automatic bit predict_step(input lineup_req_t rq, output step_cmd_t cmd);
    longint bx, by, tr, lgap, gx, gy, agy, head, d, ang_pi, ang30, ang20, a;
    bit     ok;
    cmd = '0;
    if (rq.clear) begin
      qual_cnt = 0;
      return 1'b0;
    end
    bx = longint'(rq.ball_x);
    by = longint'(rq.ball_y);
    tr = longint'(rq.turn_req);
    lgap = rq.kick_mode ? longint'($signed(cfg.side_gap)) : longint'(DRIBBLE_LEFT_GAP);
    gy = rq.foot_right ? by + lgap : by - lgap;
    gx = bx - longint'($signed(cfg.ball_standoff)) - longint'(rq.step_len);
    agy = gy < 0 ? -gy : gy;
    ok = (gx < longint'($signed(cfg.short_limit))) && (gx > longint'($signed(cfg.over_limit)))
         && (agy < longint'(cfg.side_limit));
    if (ok) begin
      if (qual_cnt < 255) qual_cnt++;
    end else if (qual_cnt > 0) begin
      qual_cnt--;
    end
    if (qual_cnt >= int'(cfg.done_count)) begin
      qual_cnt = 0;
      cmd.lined_up = 1'b1;
      return 1'b1;
    end
    ang_pi = fix_angle(PI_Z);
    ang30 = fix_angle(DEG30_Z);
    ang20 = fix_angle(DEG20_Z);
    head = ball_heading(bx, by);
    d = wrap_pi(tr - head, ang_pi);
    if (d > ang30) tr = wrap_pi(head + ang30, ang_pi);
    else if (d < -ang30) tr = wrap_pi(head - ang30, ang_pi);
    a = tr < 0 ? -tr : tr;
    a = (a * TURN_GAIN) >>> 8;
    if (a > ang20) a = ang20;
    if (tr < 0) a = -a;
    cmd.fwd_step = MOVE_W'(mag_clamp(gx, longint'(cfg.max_forward)));
    cmd.side_step = MOVE_W'(mag_clamp(gy, longint'(cfg.max_side)));
    cmd.turn_step = a[TURN_OUT_W-1:0];
    return 1'b1;
  endfunction

  // ---- stimulus helpers ---------------------------------------------------

  function automatic int pick_in(int lo, int hi);
    int t;
    if (lo > hi) begin
      t = lo; lo = hi; hi = t;
    end
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic int clip_ball(int v);
    if (v < BALL_MIN) return BALL_MIN;
    if (v > BALL_MAX) return BALL_MAX;
    return v;
  endfunction

  function automatic lineup_req_t mk_req(bit clr, int bx, int by, bit foot, bit kick,
                                         int slen, int turn);
    lineup_req_t rq;
    rq.clear = clr;
    rq.ball_x = BALL_W'(bx);
    rq.ball_y = BALL_W'(by);
    rq.foot_right = foot;
    rq.kick_mode = kick;
    rq.step_len = STEPLEN_W'(slen);
    rq.turn_req = TURN_IN_W'(turn);
    return rq;
  endfunction

  // Mostly requests steered into the qualifying window of the current
  // settings, with threshold edges hit often; the rest far away or clears.
  function automatic lineup_req_t draw_req(int near_pct, int clear_pct);
    int r, bx, by, gx, gy, lg, lo, hi, slim, slen, turn;
    bit foot, kick;
    r = $urandom_range(99);
    foot = ($urandom_range(1) != 0);
    kick = ($urandom_range(1) != 0);
    slen = $urandom_range(255);
    turn = ($urandom_range(15) == 0) ? ($urandom_range(1) ? TURN_MAX : -TURN_MAX)
                                     : pick_in(-TURN_MAX, TURN_MAX);
    bx = pick_in(BALL_MIN, BALL_MAX);
    by = pick_in(BALL_MIN, BALL_MAX);
    if (r < clear_pct) return mk_req(1'b1, bx, by, foot, kick, slen, turn);
    if (r < clear_pct + near_pct) begin
      lg = kick ? int'($signed(cfg.side_gap)) : DRIBBLE_LEFT_GAP;
      lo = int'($signed(cfg.over_limit));
      hi = int'($signed(cfg.short_limit));
      slim = int'(cfg.side_limit);
      case ($urandom_range(11))
        0: gx = lo;
        1: gx = hi;
        2: gx = lo + 1;
        3: gx = hi - 1;
        default: gx = pick_in(lo + 1, hi - 1);
      endcase
      case ($urandom_range(11))
        0: gy = slim;
        1: gy = -slim;
        2: gy = slim - 1;
        3: gy = 1 - slim;
        default: gy = pick_in(1 - slim, slim - 1);
      endcase
      bx = clip_ball(gx + int'($signed(cfg.ball_standoff)) + slen);
      by = clip_ball(foot ? gy - lg : gy + lg);
    end
    return mk_req(1'b0, bx, by, foot, kick, slen, turn);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
    case (idx)
      REG_BALL_STANDOFF: cfg.ball_standoff = GAP_W'(val);
      REG_SIDE_GAP:      cfg.side_gap = GAP_W'(val);
      REG_OVER_LIMIT:    cfg.over_limit = GAP_W'(val);
      REG_SHORT_LIMIT:   cfg.short_limit = GAP_W'(val);
      REG_SIDE_LIMIT:    cfg.side_limit = LIM_W'(val);
      REG_DONE_COUNT:    cfg.done_count = CNT_W'(val);
      REG_MAX_FORWARD:   cfg.max_forward = LIM_W'(val);
      REG_MAX_SIDE:      cfg.max_side = LIM_W'(val);
      default: ;
    endcase
  endtask

  task automatic apply_setting(input int fg, input int sg, input int ol, input int sl,
                               input int slim, input int dc, input int mf, input int ms);
    write_reg(REG_BALL_STANDOFF, fg);
    write_reg(REG_SIDE_GAP, sg);
    write_reg(REG_OVER_LIMIT, ol);
    write_reg(REG_SHORT_LIMIT, sl);
    write_reg(REG_SIDE_LIMIT, slim);
    write_reg(REG_DONE_COUNT, dc);
    write_reg(REG_MAX_FORWARD, mf);
    write_reg(REG_MAX_SIDE, ms);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || s_tvalid || expected_cmds.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // ---- driver -------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        if (predict_step(held_req, pred_cmd)) expected_cmds.push_back(pred_cmd);
        else n_clears++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle) begin
          held_req = pending_reqs.pop_front();
          s_tdata <= {3'b000, held_req.turn_req, held_req.step_len, held_req.kick_mode,
                      held_req.foot_right, held_req.ball_y, held_req.ball_x};
          s_tuser <= held_req.clear;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---- monitor ------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle);
      if (m_tvalid && m_tready) begin
        got_cmd = {m_tuser, m_tdata[9:0], m_tdata[19:10], m_tdata[31:20]};
        if (expected_cmds.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result transaction: lined=%0d fwd=%0d side=%0d turn=%0d",
                     got_cmd.lined_up, got_cmd.fwd_step, got_cmd.side_step,
                     got_cmd.turn_step);
        end else begin
          want_cmd = expected_cmds.pop_front();
          n_checked++;
          if (want_cmd.lined_up) n_lined++;
          if (got_cmd.lined_up !== want_cmd.lined_up || got_cmd.fwd_step !== want_cmd.fwd_step
              || got_cmd.side_step !== want_cmd.side_step
              || got_cmd.turn_step !== want_cmd.turn_step) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch %0d: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                       n_checked, want_cmd.lined_up, want_cmd.fwd_step, want_cmd.side_step,
                       want_cmd.turn_step, got_cmd.lined_up, got_cmd.fwd_step,
                       got_cmd.side_step, got_cmd.turn_step);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("lineup_step_controller_unit verification failed");
      $finish;
    end
  end

  // ---- sequence -----------------------------------------------------------

  initial begin
    int n_items;
    int near_pct;
    int clear_pct;
    cfg = '{ball_standoff: 10'sd0, side_gap: 10'sd0, over_limit: -10'sd35,
            short_limit: 10'sd25, side_limit: 9'd10, done_count: 8'd1,
            max_forward: 9'd60, max_side: 9'd35};
    send_idle = 16;
    recv_idle = 67;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    pending_reqs.push_back(mk_req(1'b0, BALL_MAX, BALL_MAX, 1'b1, 1'b1, 255, TURN_MAX));
    pending_reqs.push_back(mk_req(1'b0, BALL_MIN, BALL_MIN, 1'b0, 1'b0, 0, -TURN_MAX));
    pending_reqs.push_back(mk_req(1'b0, 0, 0, 1'b0, 1'b0, 0, 0));
    pending_reqs.push_back(mk_req(1'b0, 0, 0, 1'b1, 1'b1, 100, 3000));
    pending_reqs.push_back(mk_req(1'b0, -100, 0, 1'b0, 1'b1, 7, TURN_MAX));
    pending_reqs.push_back(mk_req(1'b0, -100, -1, 1'b1, 1'b0, 7, -TURN_MAX));
    pending_reqs.push_back(mk_req(1'b0, BALL_MIN, BALL_MAX, 1'b0, 1'b1, 30, -TURN_MAX));
    pending_reqs.push_back(mk_req(1'b0, BALL_MIN, -1, 1'b1, 1'b1, 30, TURN_MAX));
    pending_reqs.push_back(mk_req(1'b0, 10, 40, 1'b0, 1'b0, 0, 500));
    pending_reqs.push_back(mk_req(1'b0, 10, -40, 1'b1, 1'b0, 0, -500));
    pending_reqs.push_back(mk_req(1'b1, BALL_MAX, BALL_MIN, 1'b1, 1'b1, 255, TURN_MAX));
    pending_reqs.push_back(mk_req(1'b0, -35, 0, 1'b1, 1'b1, 0, 0));
    pending_reqs.push_back(mk_req(1'b0, 25, 9, 1'b0, 1'b1, 0, 0));
    pending_reqs.push_back(mk_req(1'b0, 24, 10, 1'b0, 1'b1, 0, 0));
    pending_reqs.push_back(mk_req(1'b0, 50, -9, 1'b0, 1'b1, 26, 0));
    pending_reqs.push_back(mk_req(1'b0, 1000, 0, 1'b0, 1'b1, 0, 1000));
    pending_reqs.push_back(mk_req(1'b0, 1000, 0, 1'b0, 1'b1, 0, 2000));
    pending_reqs.push_back(mk_req(1'b0, 0, 1000, 1'b1, 1'b0, 0, 0));
    pending_reqs.push_back(mk_req(1'b0, 200, -500, 1'b0, 1'b0, 255, -TURN_MAX));
    pending_reqs.push_back(mk_req(1'b0, BALL_MAX, 3, 1'b1, 1'b0, 128, 1));
    pending_reqs.push_back(mk_req(1'b1, 0, 0, 1'b0, 1'b0, 0, 0));
    wait_idle();

    write_reg(REG_DONE_COUNT, 0);
    @(posedge clk);
    cfg_we <= 1'b0;
    pending_reqs.push_back(mk_req(1'b0, 4000, -4000, 1'b1, 1'b0, 90, 5000));
    pending_reqs.push_back(mk_req(1'b0, 0, 0, 1'b0, 1'b1, 0, 0));
    pending_reqs.push_back(mk_req(1'b1, -5, 5, 1'b1, 1'b1, 1, -1));
    pending_reqs.push_back(mk_req(1'b0, -3000, 2500, 1'b0, 1'b1, 200, -9000));
    wait_idle();

    for (int p = 0; p < 6; p++) begin
      send_idle = (p < 2) ? 16 : (p < 4) ? 67 : 0;
      recv_idle = (p < 2) ? 67 : (p < 4) ? 16 : 0;
      n_items = 280;
      near_pct = 70;
      clear_pct = 6;
      case (p)
        0: apply_setting(100, 50, -35, 25, 10, 3, 60, 35);
        1: begin
          apply_setting(511, 511, -512, 511, 511, 255, 511, 511);
          n_items = 500;
          near_pct = 92;
          clear_pct = 0;
        end
        2: apply_setting(-512, -512, 511, -512, 0, 1, 0, 0);
        3: apply_setting(0, -40, -100, 100, 60, 8, 200, 100);
        4: apply_setting(pick_in(-200, 200), pick_in(-100, 100), pick_in(-80, 0),
                         pick_in(0, 80), pick_in(5, 80), pick_in(1, 6),
                         pick_in(0, 511), pick_in(0, 511));
        default: apply_setting(-60, 20, -20, 40, 30, 2, 120, 80);
      endcase
      for (int k = 0; k < n_items; k++) pending_reqs.push_back(draw_req(near_pct, clear_pct));
      wait_idle();
    end

    $display("checked %0d step results (%0d lined up) and %0d counter clears",
             n_checked, n_lined, n_clears);
    $display("across 8 register settings under source, sink and no-stall phases");
    if (mismatches == 0 && expected_cmds.size() == 0) begin
      $display("lineup_step_controller_unit verification clean");
    end else begin
      $display("lineup_step_controller_unit verification failed");
    end
    $finish;
  end

endmodule
